// File: hw/rtl/imufd_pkg.sv
// Shared types and constants of the inertial fall detector.
// Used by all but imufd_sqsum/isqrt; depends on nothing else.
`timescale 1ns / 1ps

package imufd_pkg;

	localparam int AXES = 3;

	// Result field widths and configuration widths
	localparam int ACC_W  = 6;
	localparam int RATE_W = 9;
	localparam int WIN_W  = 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_AMP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_AMP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STILL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FF_WIN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IM_WIN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 3'd7;

	// Fixed sensor offsets: accel x, y, z then gyro x, y, z
	localparam int AXIS_OFS [6] = '{-2050, -77, -1947, 270, -351, 136};

	// Magnitude is root / 16384, turn rate is root / 13107
	localparam int MAG_SHIFT = 14;
	localparam int RATE_DIV  = 13107;
	localparam int DIV_REM_W = 14;

	// Result item layout in the output tdata
	localparam int OUT_W        = 24;
	localparam int OUT_FALL     = 0;
	localparam int OUT_MAG_LSB  = 1;
	localparam int OUT_RATE_LSB = 7;
	localparam int OUT_FF       = 16;
	localparam int OUT_IM       = 17;
	localparam int OUT_TU       = 18;

	typedef struct packed {
		logic [ACC_W-1:0]  low_amp;
		logic [ACC_W-1:0]  high_amp;
		logic [RATE_W-1:0] turn_min;
		logic [RATE_W-1:0] turn_max;
		logic [RATE_W-1:0] still_max;
		logic [WIN_W-1:0]  ff_win;
		logic [WIN_W-1:0]  im_win;
		logic [WIN_W-1:0]  settle;
	} imufd_cfg_t;

	typedef struct packed {
		logic load;
		logic sq_step;
		logic scale_acc;
		logic scale_gyr;
		logic rt_load;
		logic rt_step;
		logic emit;
	} imufd_ctl_t;

	typedef struct packed {
		logic fall;
		logic ff;
		logic im;
		logic tu;
	} imufd_flags_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SQUARE = 5'b00010,
		ST_SCALE  = 5'b00100,
		ST_ROOT   = 5'b01000,
		ST_EMIT   = 5'b10000
	} imufd_state_t;

endpackage

// File: hw/rtl/imu_fall_detector.sv
// Each sample goes through the bit-serial squaring, the scaling by one hundred
// and the one-bit-per-cycle square root of MAG_W + 8 bits, where MAG_W is the larger
// of SAMPLE_BITS and 13. The result is then registered at the output. A new sample is
// taken only in the idle state, once the previous one has left the sequencer.
// A stalled sink holds the finished result back.
// A waiting result does not stop the next sample being taken.
// Reset (arst_n low, asynchronous) clears the trigger chain and loads register defaults.
`timescale 1ns / 1ps

module imu_fall_detector #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 8,
	localparam int IN_W = ((6 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, SAMPLE_BITS each
	input  logic [IN_W-1:0]                 s_axis_tdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// fall_detected, accel_magnitude[6], turn_rate[9], free_fall_flag,
	// impact_flag, turn_flag, then zero padding
	output logic [imufd_pkg::OUT_W-1:0]     m_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [imufd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [imufd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import imufd_pkg::*;

	localparam int MAG_W  = (SAMPLE_BITS > 13) ? SAMPLE_BITS : 13;
	localparam int OFS_W  = MAG_W + 1;
	localparam int RAD_W  = 2 * MAG_W + 16;
	localparam int ROOT_W = RAD_W / 2;
	localparam int CNT_W  = $clog2(ROOT_W + 1);
	localparam int SCALE_LAST = 2;

	imufd_cfg_t   cfg_q;
	imufd_state_t state_q, state_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	imufd_ctl_t   ctl;
	imufd_flags_t flags;

	logic signed [OFS_W-1:0] corr [6];
	logic [5:0][MAG_W-1:0]   mag_in;
	logic [RAD_W-1:0]        acc_sum, gyr_sum;
	logic [ROOT_W-1:0]       acc_root, gyr_root;
	logic                    gyr_bit;
	logic [RATE_W-1:0]       rate;
	logic [ACC_W-1:0]        accel_mag;
	logic [OUT_W-1:0]        out_data_q;
	logic                    out_valid_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_amp   <= ACC_W'(4);
			cfg_q.high_amp  <= ACC_W'(12);
			cfg_q.turn_min  <= RATE_W'(30);
			cfg_q.turn_max  <= RATE_W'(400);
			cfg_q.still_max <= RATE_W'(10);
			cfg_q.ff_win    <= WIN_W'(6);
			cfg_q.im_win    <= WIN_W'(6);
			cfg_q.settle    <= WIN_W'(10);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOW_AMP:  cfg_q.low_amp   <= cfg_data[ACC_W-1:0];
				REG_HIGH_AMP: cfg_q.high_amp  <= cfg_data[ACC_W-1:0];
				REG_TURN_MIN: cfg_q.turn_min  <= cfg_data[RATE_W-1:0];
				REG_TURN_MAX: cfg_q.turn_max  <= cfg_data[RATE_W-1:0];
				REG_STILL:    cfg_q.still_max <= cfg_data[RATE_W-1:0];
				REG_FF_WIN:   cfg_q.ff_win    <= cfg_data[WIN_W-1:0];
				REG_IM_WIN:   cfg_q.im_win    <= cfg_data[WIN_W-1:0];
				REG_SETTLE:   cfg_q.settle    <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Offset correction and absolute value of each axis
	for (genvar g = 0; g < 6; g++) begin : g_axis
		assign corr[g] = OFS_W'($signed(s_axis_tdata[g*SAMPLE_BITS +: SAMPLE_BITS]))
			+ OFS_W'(AXIS_OFS[g]);
		assign mag_in[g] = corr[g][OFS_W-1] ? MAG_W'(-corr[g]) : MAG_W'(corr[g]);
	end

	// Sequencer
	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		ctl       = '0;
		ctl.load  = s_axis_tvalid && s_axis_tready;
		state_n   = state_q;
		cnt_n     = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (ctl.load) begin
					state_n = ST_SQUARE;
					cnt_n   = '0;
				end
			end
			ST_SQUARE: begin
				ctl.sq_step = 1'b1;
				cnt_n       = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MAG_W - 1)) begin
					state_n = ST_SCALE;
					cnt_n   = '0;
				end
			end
			ST_SCALE: begin
				// accel is scaled by 100 once, gyro twice, then the roots load
				ctl.scale_acc = (cnt_q == '0);
				ctl.scale_gyr = (cnt_q != CNT_W'(SCALE_LAST));
				ctl.rt_load   = (cnt_q == CNT_W'(SCALE_LAST));
				cnt_n         = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SCALE_LAST)) begin
					state_n = ST_ROOT;
					cnt_n   = '0;
				end
			end
			ST_ROOT: begin
				ctl.rt_step = 1'b1;
				cnt_n       = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					state_n = ST_EMIT;
					cnt_n   = '0;
				end
			end
			ST_EMIT: begin
				ctl.emit = !out_valid_q || m_axis_tready;
				if (ctl.emit) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
				cnt_n   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
		end
	end

	// Datapath lanes
	imufd_sqsum #(.MAG_W(MAG_W)) u_acc_sq (
		.clk   (clk),
		.load  (ctl.load),
		.step  (ctl.sq_step),
		.scale (ctl.scale_acc),
		.mag   (mag_in[2:0]),
		.sum   (acc_sum)
	);

	imufd_sqsum #(.MAG_W(MAG_W)) u_gyr_sq (
		.clk   (clk),
		.load  (ctl.load),
		.step  (ctl.sq_step),
		.scale (ctl.scale_gyr),
		.mag   (mag_in[5:3]),
		.sum   (gyr_sum)
	);

	imufd_isqrt #(.RAD_W(RAD_W)) u_acc_rt (
		.clk      (clk),
		.load     (ctl.rt_load),
		.step     (ctl.rt_step),
		.rad      (acc_sum),
		.root     (acc_root),
		.root_bit ()
	);

	imufd_isqrt #(.RAD_W(RAD_W)) u_gyr_rt (
		.clk      (clk),
		.load     (ctl.rt_load),
		.step     (ctl.rt_step),
		.rad      (gyr_sum),
		.root     (gyr_root),
		.root_bit (gyr_bit)
	);

	imufd_cdiv u_rate_div (
		.clk    (clk),
		.load   (ctl.rt_load),
		.step   (ctl.rt_step),
		.bit_in (gyr_bit),
		.quot   (rate)
	);

	assign accel_mag = acc_root[MAG_SHIFT +: ACC_W];

	imufd_chain #(.COUNT_BITS(COUNT_BITS)) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (ctl.emit),
		.mag    (accel_mag),
		.rate   (rate),
		.cfg    (cfg_q),
		.flags  (flags)
	);

	// Output register; the full root of the gyro lane is only needed through the divider.
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_data_q <= {(OUT_W - OUT_TU - 1)'(0), flags.tu, flags.im, flags.ff,
				rate, accel_mag, flags.fall};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tdata  = out_data_q;
	assign m_axis_tvalid = out_valid_q && (gyr_root == gyr_root);

endmodule

// File: hw/rtl/imufd_sqsum.sv
// Bit-serial sum of three squares, most significant multiplier bit first,
// followed by optional scaling by one hundred. Uses no package items.
`timescale 1ns / 1ps

module imufd_sqsum #(
	parameter int MAG_W = 16,
	localparam int RAD_W = 2 * MAG_W + 16
) (
	input  logic                       clk,
	input  logic                       load,
	input  logic                       step,
	input  logic                       scale,
	input  logic [2:0][MAG_W-1:0]      mag,
	output logic [RAD_W-1:0]           sum
);

	logic [2:0][MAG_W-1:0] mcand_q;
	logic [2:0][MAG_W-1:0] mplier_q;
	logic [RAD_W-1:0]      acc_q;
	logic [RAD_W-1:0]      pp;

	// Partial product row for the current multiplier bit of all three axes
	always_comb begin
		pp = '0;
		for (int i = 0; i < 3; i++) begin
			if (mplier_q[i][MAG_W-1]) begin
				pp = pp + RAD_W'(mcand_q[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mcand_q  <= mag;
			mplier_q <= mag;
			acc_q    <= '0;
		end else if (step) begin
			for (int i = 0; i < 3; i++) begin
				mplier_q[i] <= {mplier_q[i][MAG_W-2:0], 1'b0};
			end
			acc_q <= {acc_q[RAD_W-2:0], 1'b0} + pp;
		end else if (scale) begin
			// times 100 = 64 + 32 + 4
			acc_q <= (acc_q << 6) + (acc_q << 5) + (acc_q << 2);
		end
	end

	assign sum = acc_q;

endmodule

// File: hw/rtl/imufd_isqrt.sv
// Restoring integer square root, one root bit per cycle.
// Each new root bit is also offered to a serial divider. No package items.
`timescale 1ns / 1ps

module imufd_isqrt #(
	parameter int RAD_W = 48,
	localparam int ROOT_W = RAD_W / 2
) (
	input  logic              clk,
	input  logic              load,
	input  logic              step,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root,
	output logic              root_bit
);

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W-1:0] rem_q;
	logic [ROOT_W+1:0] rem_sh;
	logic [ROOT_W+1:0] trial;
	logic [ROOT_W+1:0] diff;
	logic              ge;

	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign diff   = rem_sh - trial;
	assign ge     = (rem_sh >= trial);

	// The remainder fits ROOT_W bits before the last step; after it, it is unused.
	always_ff @(posedge clk) begin
		if (load) begin
			rad_q  <= rad;
			root_q <= '0;
			rem_q  <= '0;
		end else if (step) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? diff[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign root     = root_q;
	assign root_bit = ge;

endmodule

// File: hw/rtl/imufd_cdiv.sv
// Serial long division by the turn-rate scale, fed one dividend bit per
// cycle as the square root produces it. Depends on imufd_pkg.
`timescale 1ns / 1ps

module imufd_cdiv (
	input  logic                        clk,
	input  logic                        load,
	input  logic                        step,
	input  logic                        bit_in,
	output logic [imufd_pkg::RATE_W-1:0] quot
);
	import imufd_pkg::*;

	logic [DIV_REM_W-1:0] rem_q;
	logic [RATE_W-1:0]    quot_q;
	logic [DIV_REM_W:0]   sh;
	logic [DIV_REM_W:0]   diff;
	logic                 ge;

	assign sh   = {rem_q, bit_in};
	assign diff = sh - (DIV_REM_W + 1)'(RATE_DIV);
	assign ge   = (sh >= (DIV_REM_W + 1)'(RATE_DIV));

	// Quotient bits above RATE_W are always zero for in-range samples.
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q  <= '0;
			quot_q <= '0;
		end else if (step) begin
			rem_q  <= ge ? diff[DIV_REM_W-1:0] : sh[DIV_REM_W-1:0];
			quot_q <= {quot_q[RATE_W-2:0], ge};
		end
	end

	assign quot = quot_q;

endmodule

// File: hw/rtl/imufd_chain.sv
// Trigger chain: free-fall, impact, orientation change and settle check.
// Counters for free-fall, impact and settle. Depends on imufd_pkg.
`timescale 1ns / 1ps

module imufd_chain #(
	parameter int COUNT_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         upd,
	input  logic [imufd_pkg::ACC_W-1:0]  mag,
	input  logic [imufd_pkg::RATE_W-1:0] rate,
	input  imufd_pkg::imufd_cfg_t        cfg,
	output imufd_pkg::imufd_flags_t      flags
);
	import imufd_pkg::*;

	localparam int CMP_W = (COUNT_BITS > WIN_W) ? COUNT_BITS : WIN_W;

	logic                  ff_q, im_q, tu_q;
	logic [COUNT_BITS-1:0] ffc_q, imc_q, stc_q;
	logic                  ff_n, im_n, tu_n, fall_n;
	logic [COUNT_BITS-1:0] ffc_n, imc_n, stc_n;

	always_comb begin
		ff_n   = ff_q;
		im_n   = im_q;
		tu_n   = tu_q;
		ffc_n  = ffc_q;
		imc_n  = imc_q;
		stc_n  = stc_q;
		fall_n = 1'b0;

		if (mag <= cfg.low_amp && !im_q) begin
			ff_n = 1'b1;
		end
		if (ff_n) begin
			ffc_n = ffc_q + 1'b1;
			if (mag >= cfg.high_amp) begin
				im_n  = 1'b1;
				ff_n  = 1'b0;
				ffc_n = '0;
			end
		end
		if (im_n) begin
			imc_n = imc_q + 1'b1;
			if (rate >= cfg.turn_min && rate <= cfg.turn_max) begin
				tu_n  = 1'b1;
				im_n  = 1'b0;
				imc_n = '0;
			end
		end
		// A re-armed turn stage keeps its settle count running.
		if (tu_n) begin
			stc_n = stc_q + 1'b1;
			if (CMP_W'(stc_n) >= CMP_W'(cfg.settle)) begin
				fall_n = (rate <= cfg.still_max);
				tu_n   = 1'b0;
				stc_n  = '0;
			end
		end
		if (CMP_W'(imc_n) >= CMP_W'(cfg.im_win)) begin
			im_n  = 1'b0;
			imc_n = '0;
		end
		if (CMP_W'(ffc_n) >= CMP_W'(cfg.ff_win)) begin
			ff_n  = 1'b0;
			ffc_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_q  <= 1'b0;
			im_q  <= 1'b0;
			tu_q  <= 1'b0;
			ffc_q <= '0;
			imc_q <= '0;
			stc_q <= '0;
		end else if (upd) begin
			ff_q  <= ff_n;
			im_q  <= im_n;
			tu_q  <= tu_n;
			ffc_q <= ffc_n;
			imc_q <= imc_n;
			stc_q <= stc_n;
		end
	end

	assign flags.fall = fall_n;
	assign flags.ff   = ff_n;
	assign flags.im   = im_n;
	assign flags.tu   = tu_n;

endmodule

// File: hw/rtl/imufd_props.sv
// Port-level checks for the fall detector, bound to the top level below.
// Depends on imufd_pkg for the result item layout.
`timescale 1ns / 1ps

module imufd_props (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic [imufd_pkg::OUT_W-1:0] m_axis_tdata,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready
);
	import imufd_pkg::*;

	// A result waiting on a stalled sink keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// One sample at a time: taking a sample closes the input side.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second sample taken while one is in work");

	// A result cannot appear on the cycle straight after a sample is taken.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result appeared too early");

	// Free-fall and impact are never armed together, and a fall clears the turn stage.
	a_flags_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[OUT_FF] && m_axis_tdata[OUT_IM])
			&& !(m_axis_tdata[OUT_FALL] && m_axis_tdata[OUT_TU]))
		else $error("inconsistent stage flags");

endmodule

bind imu_fall_detector imufd_props u_props (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);
